// ===== rtl/stig_pkg.sv =====
// stig_pkg: shared widths and triangle phase codes for the sphere triangle index generator
// used by the channel interfaces and the core; no dependencies

package stig_pkg;

    localparam int INDEX_W = 13;
    localparam int HDIV_W  = 6;
    localparam int PHASE_W = 2;

    localparam logic [PHASE_W-1:0] PH_TOP_CAP    = 2'd0;
    localparam logic [PHASE_W-1:0] PH_BAND_FIRST = 2'd1;
    localparam logic [PHASE_W-1:0] PH_BAND_SECOND = 2'd2;
    localparam logic [PHASE_W-1:0] PH_BOTTOM_CAP = 2'd3;

    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [HDIV_W-1:0]  hdiv_t;
    typedef logic [PHASE_W-1:0] phase_t;

endpackage

// ===== rtl/stig_if.sv =====
// stig_if: valid/ready channel interfaces for request items and triangle items
// depends on stig_pkg for the index width

interface stig_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface stig_tri_if;
    logic               valid;
    logic               ready;
    stig_pkg::index_t   corner_first;
    stig_pkg::index_t   corner_second;
    stig_pkg::index_t   corner_third;
    logic               mesh_done;

    modport source (output valid, output corner_first, output corner_second,
                    output corner_third, output mesh_done, input ready);
    modport sink   (input valid, input corner_first, input corner_second,
                    input corner_third, input mesh_done, output ready);
endinterface

// ===== rtl/sphere_triangle_index_generator_core.sv =====
// a triangle item is registered and appears in the cycle after its request item is taken
// one triangle per cycle if not stalled; output register reloads in the cycle it is drained
// the sequence counters and running sector bases update in one pass per item
// reset: sector 0 top cap, half_divisions = min(8, MAX_HALF_DIVISIONS); writes also restart
// sphere_triangle_index_generator_core: uv sphere triangle index sequencer
// depends on stig_pkg and the channel interfaces in stig_if.sv

module sphere_triangle_index_generator_core #(
    parameter int MAX_HALF_DIVISIONS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  half_divisions_we,
    input  stig_pkg::hdiv_t       half_divisions_wdata,
    stig_req_if.sink              request,
    stig_tri_if.source            triangle
);
    import stig_pkg::*;

    localparam int HW = $clog2(MAX_HALF_DIVISIONS + 1);
    localparam int NW = $clog2(2 * MAX_HALF_DIVISIONS + 1);
    localparam int SW = $clog2(4 * MAX_HALF_DIVISIONS + 1);
    localparam int RST_H = (8 > MAX_HALF_DIVISIONS) ? MAX_HALF_DIVISIONS : 8;
    localparam int RST_N = 2 * RST_H;
    localparam int RST_POLE = ((RST_N - 1) * 2 * RST_N + 1) % (1 << INDEX_W);

    // size registers, derived at write time
    logic [NW-1:0] n_reg;
    index_t        nm1_reg;
    logic [SW-1:0] sectors_reg;
    index_t        pole_reg;
    logic          inner_reg;

    // sequence state
    logic [SW-1:0] sector_count_reg, sector_count_next;
    logic [NW-1:0] band_count_reg, band_count_next;
    phase_t        phase_reg, phase_next;
    index_t        sector_base_reg, sector_base_next;
    index_t        next_base_reg, next_base_next;

    // output register
    logic          out_valid_reg;
    index_t        a_reg, b_reg, c_reg;
    logic          done_reg;
    index_t        a_next, b_next, c_next;
    logic          done_next;

    // config decode
    logic [HW-1:0] h_clamp;
    logic [NW-1:0] n_cfg;
    index_t        nm1_cfg;
    index_t        sec13_cfg;
    index_t        pole_cfg;

    always_comb
    begin
        if (half_divisions_wdata == '0)
            h_clamp = HW'(1);
        else if (32'(half_divisions_wdata) > 32'(MAX_HALF_DIVISIONS))
            h_clamp = HW'(MAX_HALF_DIVISIONS);
        else
            h_clamp = HW'(half_divisions_wdata);
        n_cfg     = NW'({h_clamp, 1'b0});
        nm1_cfg   = INDEX_W'(n_cfg) - INDEX_W'(1);
        sec13_cfg = INDEX_W'({n_cfg, 1'b0});
        pole_cfg  = INDEX_W'(nm1_cfg * sec13_cfg) + INDEX_W'(1);
    end

    logic accept;
    assign request.ready = !out_valid_reg || triangle.ready;
    assign accept        = request.valid && request.ready;

    // effective state after an optional restart
    logic [SW-1:0] sc;
    logic [NW-1:0] bc;
    phase_t        ph;
    index_t        sb, nb, bc13;
    logic [SW:0]   sc_inc, sc_inc2;

    always_comb
    begin
        if (request.restart)
        begin
            sc = '0;
            bc = '0;
            ph = PH_TOP_CAP;
            sb = '0;
            nb = nm1_reg;
        end
        else
        begin
            sc = sector_count_reg;
            bc = band_count_reg;
            ph = phase_reg;
            sb = sector_base_reg;
            nb = next_base_reg;
        end
        bc13    = INDEX_W'(bc);
        sc_inc  = {1'b0, sc} + (SW+1)'(1);
        sc_inc2 = {1'b0, sc} + (SW+1)'(2);

        sector_count_next = sc;
        band_count_next   = bc;
        phase_next        = ph;
        sector_base_next  = sb;
        next_base_next    = nb;
        done_next         = 1'b0;

        case (ph)
            PH_TOP_CAP:
            begin
                a_next = '0;
                b_next = sb + INDEX_W'(1);
                c_next = nb + INDEX_W'(1);
                if (inner_reg)
                begin
                    band_count_next = NW'(1);
                    phase_next      = PH_BAND_FIRST;
                end
                else
                    phase_next = PH_BOTTOM_CAP;
            end
            PH_BAND_FIRST:
            begin
                a_next     = sb + bc13;
                b_next     = sb + bc13 + INDEX_W'(1);
                c_next     = nb + bc13;
                phase_next = PH_BAND_SECOND;
            end
            PH_BAND_SECOND:
            begin
                a_next = nb + bc13;
                b_next = sb + bc13 + INDEX_W'(1);
                c_next = nb + bc13 + INDEX_W'(1);
                if (({1'b0, bc} + (NW+1)'(2)) < {1'b0, n_reg})
                begin
                    band_count_next = bc + NW'(1);
                    phase_next      = PH_BAND_FIRST;
                end
                else
                    phase_next = PH_BOTTOM_CAP;
            end
            default:
            begin
                a_next = sb + nm1_reg;
                b_next = pole_reg;
                c_next = nb + nm1_reg;
                if (sc_inc >= {1'b0, sectors_reg})
                begin
                    done_next         = 1'b1;
                    sector_count_next = '0;
                    sector_base_next  = '0;
                    next_base_next    = nm1_reg;
                end
                else
                begin
                    sector_count_next = sc_inc[SW-1:0];
                    sector_base_next  = nb;
                    // last sector wraps its neighbor back to sector 0
                    next_base_next    = (sc_inc2 >= {1'b0, sectors_reg}) ? '0 : nb + nm1_reg;
                end
                band_count_next = '0;
                phase_next      = PH_TOP_CAP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg            <= NW'(RST_N);
            nm1_reg          <= INDEX_W'(RST_N - 1);
            sectors_reg      <= SW'(2 * RST_N);
            pole_reg         <= INDEX_W'(RST_POLE);
            inner_reg        <= (RST_N >= 3);
            sector_count_reg <= '0;
            band_count_reg   <= '0;
            phase_reg        <= PH_TOP_CAP;
            sector_base_reg  <= '0;
            next_base_reg    <= INDEX_W'(RST_N - 1);
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (half_divisions_we)
            begin
                n_reg            <= n_cfg;
                nm1_reg          <= nm1_cfg;
                sectors_reg      <= SW'({n_cfg, 1'b0});
                pole_reg         <= pole_cfg;
                inner_reg        <= (h_clamp >= HW'(2)) && (HW > 1);
                sector_count_reg <= '0;
                band_count_reg   <= '0;
                phase_reg        <= PH_TOP_CAP;
                sector_base_reg  <= '0;
                next_base_reg    <= nm1_cfg;
            end
            else if (accept)
            begin
                sector_count_reg <= sector_count_next;
                band_count_reg   <= band_count_next;
                phase_reg        <= phase_next;
                sector_base_reg  <= sector_base_next;
                next_base_reg    <= next_base_next;
            end

            if (accept)
                out_valid_reg <= 1'b1;
            else if (triangle.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            c_reg    <= c_next;
            done_reg <= done_next;
        end
    end

    assign triangle.valid         = out_valid_reg;
    assign triangle.corner_first  = a_reg;
    assign triangle.corner_second = b_reg;
    assign triangle.corner_third  = c_reg;
    assign triangle.mesh_done     = done_reg;

endmodule
